// File: rtl/dad_pkg.sv
// Shared types, constants and calendar functions for the date adder.
`timescale 1ns / 1ps

package dad_pkg;

  localparam int OFFSET_BITS   = 20;
  localparam int DAY_OFFSET_W  = 20;
  localparam int START_YEAR_W  = 14;
  localparam int MONTH_W       = 4;
  localparam int DAY_W         = 5;
  localparam int CFG_IDX_W     = 2;
  localparam int CFG_DATA_W    = 14;

  // Offset bits that actually reach the adder.
  localparam int OFF_USE_W = (OFFSET_BITS < DAY_OFFSET_W) ? OFFSET_BITS : DAY_OFFSET_W;
  // Offset plus the zero-based day of the year.
  localparam int TOT_W     = OFF_USE_W + 2;
  // Start year plus the whole years that the offset can hold.
  localparam int YEAR_W    = (((OFF_USE_W - 8) > START_YEAR_W) ?
                               (OFF_USE_W - 8) : START_YEAR_W) + 1;
  localparam int YMOD_W    = 9;

  localparam int unsigned CYCLE_DAYS  = 146097;
  localparam int unsigned CYCLE_YEARS = 400;
  localparam int unsigned COMMON_DAYS = 365;
  localparam int unsigned LEAP_DAYS   = 366;
  localparam int unsigned MONTHS      = 12;

  localparam logic [MONTH_W-1:0] MONTH_FEB = 4'd2;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_START_YEAR  = 2'd0,
    CFG_START_MONTH = 2'd1,
    CFG_START_DAY   = 2'd2
  } cfg_idx_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_MOD,
    S_DOY,
    S_CYC,
    S_YEAR,
    S_MON,
    S_FIN
  } state_t;

  typedef struct packed {
    logic load;
    logic mod_step;
    logic doy_add;
    logic cyc_step;
    logic year_step;
    logic mon_step;
    logic out_load;
  } dad_cmd_t;

  typedef struct packed {
    logic mod_ge;
    logic invalid;
    logic cyc_ge;
    logic year_ge;
    logic mon_ge;
    logic out_free;
  } dad_stat_t;

  // Leap test on the year modulo 400: divisible by 4, not a plain century.
  function automatic logic is_leap(input logic [YMOD_W-1:0] ymod);
    return (ymod[1:0] == 2'd0) && !(ymod inside {9'd100, 9'd200, 9'd300});
  endfunction

  function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] m,
                                                 input logic leap);
    logic [DAY_W-1:0] n;
    case (m) inside
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: n = 5'd31;
      4'd4, 4'd6, 4'd9, 4'd11:                    n = 5'd30;
      4'd2:                                       n = leap ? 5'd29 : 5'd28;
      default:                                    n = 5'd0;
    endcase
    return n;
  endfunction

  // Days in the months before month m.
  function automatic logic [8:0] days_before(input logic [MONTH_W-1:0] m,
                                             input logic leap);
    logic [8:0] n;
    case (m)
      4'd1:    n = 9'd0;
      4'd2:    n = 9'd31;
      4'd3:    n = 9'd59;
      4'd4:    n = 9'd90;
      4'd5:    n = 9'd120;
      4'd6:    n = 9'd151;
      4'd7:    n = 9'd181;
      4'd8:    n = 9'd212;
      4'd9:    n = 9'd243;
      4'd10:   n = 9'd273;
      4'd11:   n = 9'd304;
      4'd12:   n = 9'd334;
      default: n = 9'd0;
    endcase
    if (leap && (m > MONTH_FEB)) begin
      n = n + 9'd1;
    end
    return n;
  endfunction

endpackage

// File: rtl/dad_ctrl.sv
// Sequencer that steps the date datapath through its reduction loops.
`timescale 1ns / 1ps

module dad_ctrl
  import dad_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  dad_stat_t stat,
  output dad_cmd_t  cmd
);

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: if (in_valid) state_nxt = S_MOD;
      S_MOD:  if (!stat.mod_ge) state_nxt = S_DOY;
      S_DOY:  state_nxt = stat.invalid ? S_FIN : S_CYC;
      S_CYC:  if (!stat.cyc_ge) state_nxt = S_YEAR;
      S_YEAR: if (!stat.year_ge) state_nxt = S_MON;
      S_MON:  if (!stat.mon_ge) state_nxt = S_FIN;
      S_FIN:  if (stat.out_free) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      S_MOD:  cmd.mod_step  = stat.mod_ge;
      S_DOY:  cmd.doy_add   = 1'b1;
      S_CYC:  cmd.cyc_step  = stat.cyc_ge;
      S_YEAR: cmd.year_step = stat.year_ge;
      S_MON:  cmd.mon_step  = stat.mon_ge;
      S_FIN:  cmd.out_load  = stat.out_free;
      default: cmd = '0;
    endcase
  end

endmodule

// File: rtl/dad_dpath.sv
// Datapath: start date registers, day count, year and month reduction, result register.
`timescale 1ns / 1ps

module dad_dpath
  import dad_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    cfg_valid,
  input  logic [CFG_IDX_W-1:0]    cfg_index,
  input  logic [CFG_DATA_W-1:0]   cfg_data,
  input  logic [DAY_OFFSET_W-1:0] in_day_offset,
  input  logic                    out_ready,
  output logic                    out_valid,
  output logic [START_YEAR_W-1:0] out_result_year,
  output logic [MONTH_W-1:0]      out_result_month,
  output logic [DAY_W-1:0]        out_result_day,
  output logic                    out_start_invalid,
  input  dad_cmd_t                cmd,
  output dad_stat_t               stat
);

  logic [START_YEAR_W-1:0] start_year_r;
  logic [MONTH_W-1:0]      start_month_r;
  logic [DAY_W-1:0]        start_day_r;

  logic [TOT_W-1:0]        total_r;
  logic [YEAR_W-1:0]       year_r;
  logic [START_YEAR_W-1:0] ymod_r;
  logic [MONTH_W-1:0]      mon_r;
  logic                    inv_r;

  logic                    out_valid_r, out_valid_nxt;
  logic [START_YEAR_W-1:0] out_year_r;
  logic [MONTH_W-1:0]      out_month_r;
  logic [DAY_W-1:0]        out_day_r;
  logic                    out_inv_r;

  logic             leap;
  logic [DAY_W-1:0] start_len;
  logic [DAY_W-1:0] cur_len;
  logic [8:0]       year_len;
  logic             bad_start;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_year_r  <= START_YEAR_W'(2000);
      start_month_r <= MONTH_W'(1);
      start_day_r   <= DAY_W'(1);
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_START_YEAR:  start_year_r  <= cfg_data[START_YEAR_W-1:0];
        CFG_START_MONTH: start_month_r <= cfg_data[MONTH_W-1:0];
        CFG_START_DAY:   start_day_r   <= cfg_data[DAY_W-1:0];
        default: ;
      endcase
    end
  end

  // ymod_r holds the year modulo 400 once the reduction loop is done
  assign leap      = is_leap(ymod_r[YMOD_W-1:0]);
  assign start_len = month_len(start_month_r, leap);
  assign cur_len   = month_len(mon_r, leap);
  assign year_len  = leap ? 9'(LEAP_DAYS) : 9'(COMMON_DAYS);
  assign bad_start = (start_month_r < MONTH_W'(1)) || (start_month_r > MONTH_W'(MONTHS)) ||
                     (start_day_r == '0) || (start_day_r > start_len);

  always_comb begin
    stat.mod_ge   = ymod_r >= START_YEAR_W'(CYCLE_YEARS);
    stat.invalid  = bad_start;
    stat.cyc_ge   = 32'(total_r) >= CYCLE_DAYS;
    stat.year_ge  = total_r >= TOT_W'(year_len);
    stat.mon_ge   = (mon_r < MONTH_W'(MONTHS)) && (total_r >= TOT_W'(cur_len));
    stat.out_free = !out_valid_r || out_ready;
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      total_r <= TOT_W'(in_day_offset[OFF_USE_W-1:0]);
      year_r  <= YEAR_W'(start_year_r);
      ymod_r  <= start_year_r;
      mon_r   <= MONTH_W'(1);
      inv_r   <= 1'b0;
    end
    if (cmd.mod_step) begin
      ymod_r <= ymod_r - START_YEAR_W'(CYCLE_YEARS);
    end
    if (cmd.doy_add) begin
      inv_r   <= bad_start;
      total_r <= total_r + TOT_W'(start_day_r) +
                 TOT_W'(days_before(start_month_r, leap)) - TOT_W'(1);
    end
    if (cmd.cyc_step) begin
      total_r <= total_r - TOT_W'(CYCLE_DAYS);
      year_r  <= year_r + YEAR_W'(CYCLE_YEARS);
    end
    if (cmd.year_step) begin
      total_r <= total_r - TOT_W'(year_len);
      year_r  <= year_r + YEAR_W'(1);
      // wrap the year modulo 400
      ymod_r  <= (ymod_r == START_YEAR_W'(CYCLE_YEARS - 1)) ? '0 : ymod_r + START_YEAR_W'(1);
    end
    if (cmd.mon_step) begin
      total_r <= total_r - TOT_W'(cur_len);
      mon_r   <= mon_r + MONTH_W'(1);
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      if (inv_r) begin
        out_year_r  <= '0;
        out_month_r <= '0;
        out_day_r   <= '0;
      end else begin
        out_year_r  <= year_r[START_YEAR_W-1:0];
        out_month_r <= mon_r;
        out_day_r   <= total_r[DAY_W-1:0] + DAY_W'(1);
      end
      out_inv_r <= inv_r;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_result_year   = out_year_r;
  assign out_result_month  = out_month_r;
  assign out_result_day    = out_day_r;
  assign out_start_invalid = out_inv_r;

endmodule

// File: rtl/date_add_days.sv
// Top level of the Gregorian date adder: start date plus a day offset.
//
// Usage: write the start date (year, month, day) on the cfg channel, index 0, 1
// and 2, while the block is idle; cfg_ready is always high. Each item on the in
// channel carries a day offset; the block answers with one item on the out
// channel: year, month and day of start date plus offset, or a zero date with
// start_invalid set when the start date is not a real date.
// An item is reduced in order: start year modulo 400, day of the year, whole
// 400-year cycles, single years (one year a cycle), then months. One item is
// in work at a time; in_ready is high only while the sequencer is idle.
// The finished result sits in an output register, so a new item is accepted
// while the receiver stalls; a second result waits in the sequencer until the
// register frees up.
// Reset (rst_n low, synchronous) sets the start date to 2000-01-01, empties the
// output register and returns the sequencer to idle.
`timescale 1ns / 1ps

module date_add_days
  import dad_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    cfg_valid,
  output logic                    cfg_ready,
  input  logic [CFG_IDX_W-1:0]    cfg_index,
  input  logic [CFG_DATA_W-1:0]   cfg_data,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic [DAY_OFFSET_W-1:0] in_day_offset,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic [START_YEAR_W-1:0] out_result_year,
  output logic [MONTH_W-1:0]      out_result_month,
  output logic [DAY_W-1:0]        out_result_day,
  output logic                    out_start_invalid
);

  dad_cmd_t  cmd;
  dad_stat_t stat;

  assign cfg_ready = 1'b1;

  dad_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  dad_dpath u_dpath (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_valid         (cfg_valid),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .in_day_offset     (in_day_offset),
    .out_ready         (out_ready),
    .out_valid         (out_valid),
    .out_result_year   (out_result_year),
    .out_result_month  (out_result_month),
    .out_result_day    (out_result_day),
    .out_start_invalid (out_start_invalid),
    .cmd               (cmd),
    .stat              (stat)
  );

`ifndef SYNTHESIS
  // one item at a time: acceptance closes the input
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input accepted while an item is in work");

  // an invalid start gives a zero date
  a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_start_invalid |->
      (out_result_year == '0) && (out_result_month == '0) && (out_result_day == '0))
    else $error("invalid start date with nonzero result");

  // a valid result has a real month and day
  a_valid_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_start_invalid |->
      (out_result_month >= MONTH_W'(1)) && (out_result_month <= MONTH_W'(MONTHS)) &&
      (out_result_day != '0))
    else $error("result month or day out of range");
`endif

endmodule

// File: tb/date_add_days_check.sv
// Checker for the date adder: predicts each resulting date and compares it on the out channel.
`timescale 1ns / 1ps

module date_add_days_check
  import dad_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    cfg_valid,
  input  logic                    cfg_ready,
  input  logic [CFG_IDX_W-1:0]    cfg_index,
  input  logic [CFG_DATA_W-1:0]   cfg_data,
  input  logic                    in_valid,
  input  logic                    in_ready,
  input  logic [DAY_OFFSET_W-1:0] in_day_offset,
  input  logic                    out_valid,
  input  logic                    out_ready,
  input  logic [START_YEAR_W-1:0] out_result_year,
  input  logic [MONTH_W-1:0]      out_result_month,
  input  logic [DAY_W-1:0]        out_result_day,
  input  logic                    out_start_invalid,
  output int                      fail_count,
  output int                      pending
);

  typedef struct packed {
    logic [DAY_OFFSET_W-1:0] offset;
    logic [START_YEAR_W-1:0] year;
    logic [MONTH_W-1:0]      month;
    logic [DAY_W-1:0]        day;
    logic                    invalid;
  } dated_t;

  logic [START_YEAR_W-1:0] cfg_year  = 14'd2000;
  logic [MONTH_W-1:0]      cfg_month = 4'd1;
  logic [DAY_W-1:0]        cfg_day   = 5'd1;
  dated_t                  due_dates[$];
  int                      reported  = 0;

  function automatic bit leap_year(input int unsigned y);
    return ((y % 4) == 0 && (y % 100) != 0) || (y % 400) == 0;
  endfunction

  function automatic int unsigned days_in_month(input int unsigned m, input int unsigned y);
    case (m)
      4, 6, 9, 11: return 30;
      2:           return leap_year(y) ? 29 : 28;
      default:     return 31;
    endcase
  endfunction

  // Start date plus offset, with the year loop done one year at a time after
  // whole 400-year cycles are taken out.
  function automatic dated_t shifted_date(input logic [DAY_OFFSET_W-1:0] off);
    dated_t           r;
    longint unsigned  rest;
    int unsigned      y;
    int unsigned      m;
    int unsigned      n;
    r = '0;
    r.offset = off;
    if (cfg_month < 1 || cfg_month > MONTHS || cfg_day < 1 ||
        cfg_day > days_in_month(cfg_month, cfg_year)) begin
      r.invalid = 1'b1;
      return r;
    end
    y = cfg_year;
    rest = cfg_day - 1;
    for (m = 1; m < cfg_month; m++) begin
      rest += days_in_month(m, y);
    end
    rest += off & ((64'd1 << OFFSET_BITS) - 1);
    while (rest >= CYCLE_DAYS) begin
      rest -= CYCLE_DAYS;
      y += CYCLE_YEARS;
    end
    n = leap_year(y) ? LEAP_DAYS : COMMON_DAYS;
    while (rest >= n) begin
      rest -= n;
      y++;
      n = leap_year(y) ? LEAP_DAYS : COMMON_DAYS;
    end
    m = 1;
    while (m < MONTHS && rest >= days_in_month(m, y)) begin
      rest -= days_in_month(m, y);
      m++;
    end
    r.year  = y[START_YEAR_W-1:0];
    r.month = m[MONTH_W-1:0];
    r.day   = DAY_W'(rest + 1);
    return r;
  endfunction

  always @(posedge clk) begin : watch
    dated_t want;
    if (!rst_n) begin
      cfg_year  = 14'd2000;
      cfg_month = 4'd1;
      cfg_day   = 5'd1;
      due_dates.delete();
    end else begin
      if (out_valid && out_ready) begin
        if (due_dates.size() == 0) begin
          fail_count++;
          if (reported < 10) begin
            $display("unexpected date %0d-%0d-%0d invalid=%0b with nothing pending",
                     out_result_year, out_result_month, out_result_day, out_start_invalid);
          end
          reported++;
        end else begin
          want = due_dates.pop_front();
          if (out_result_year !== want.year || out_result_month !== want.month ||
              out_result_day !== want.day || out_start_invalid !== want.invalid) begin
            fail_count++;
            if (reported < 10) begin
              $display("date mismatch, offset %0d: expected %0d-%0d-%0d invalid=%0b, got %0d-%0d-%0d invalid=%0b",
                       want.offset, want.year, want.month, want.day, want.invalid,
                       out_result_year, out_result_month, out_result_day, out_start_invalid);
            end
            reported++;
          end
        end
      end
      // predict with the date in force before any write on this edge
      if (in_valid && in_ready) begin
        due_dates.push_back(shifted_date(in_day_offset));
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_START_YEAR:  cfg_year  = cfg_data[START_YEAR_W-1:0];
          CFG_START_MONTH: cfg_month = cfg_data[MONTH_W-1:0];
          CFG_START_DAY:   cfg_day   = cfg_data[DAY_W-1:0];
          default: ;  // no register behind this index: drop the write
        endcase
      end
    end
    pending = due_dates.size();
  end

endmodule

// File: tb/testbench.sv
// Stimulus and verdict for the date adder: directed dates, then random start dates and offsets.
`timescale 1ns / 1ps

module testbench;
  import dad_pkg::*;

  localparam logic [CFG_IDX_W-1:0] CFG_NO_REG = 2'd3;
  localparam int ITEMS  = 200;
  localparam int SETTLE = 500;

  logic                    clk           = 1'b0;
  logic                    rst_n         = 1'b0;
  logic                    cfg_valid     = 1'b0;
  logic [CFG_IDX_W-1:0]    cfg_index     = '0;
  logic [CFG_DATA_W-1:0]   cfg_data      = '0;
  logic                    in_valid      = 1'b0;
  logic [DAY_OFFSET_W-1:0] in_day_offset = '0;
  logic                    out_ready     = 1'b0;
  logic                    cfg_ready;
  logic                    in_ready;
  logic                    out_valid;
  logic [START_YEAR_W-1:0] out_result_year;
  logic [MONTH_W-1:0]      out_result_month;
  logic [DAY_W-1:0]        out_result_day;
  logic                    out_start_invalid;
  int                      fail_count;
  int                      pending;

  date_add_days u_top (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_day_offset     (in_day_offset),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_result_year   (out_result_year),
    .out_result_month  (out_result_month),
    .out_result_day    (out_result_day),
    .out_start_invalid (out_start_invalid)
  );

  date_add_days_check u_check (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_day_offset     (in_day_offset),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_result_year   (out_result_year),
    .out_result_month  (out_result_month),
    .out_result_day    (out_result_day),
    .out_start_invalid (out_start_invalid),
    .fail_count        (fail_count),
    .pending           (pending)
  );

  always #1 clk = ~clk;

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
  end

  initial begin
    #2_000_000;
    $display("tb: failure");
    $finish;
  end

  // Mostly no gap or a short one, now and then a long one.
  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 45) return 0;
    if (roll < 80) return $urandom_range(1, 3);
    if (roll < 96) return $urandom_range(4, 12);
    return $urandom_range(20, 80);
  endfunction

  function automatic logic [DAY_OFFSET_W-1:0] random_offset();
    case ($urandom_range(0, 9))
      0, 1, 2: return DAY_OFFSET_W'($urandom_range(0, 400));
      3, 4:    return DAY_OFFSET_W'($urandom_range(0, 3000));
      5, 6, 7: return DAY_OFFSET_W'($urandom);
      8:       return DAY_OFFSET_W'(CYCLE_DAYS * $urandom_range(1, 7) + $urandom_range(0, 4) - 2);
      default: return DAY_OFFSET_W'(20'hFFFFF - $urandom_range(0, 500));
    endcase
  endfunction

  // Leaves cfg_valid high; the caller drops it after the last write.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
  endtask

  task automatic set_start(input logic [CFG_DATA_W-1:0] y, input logic [CFG_DATA_W-1:0] m,
                           input logic [CFG_DATA_W-1:0] d);
    write_reg(CFG_START_YEAR, y);
    write_reg(CFG_START_MONTH, m);
    write_reg(CFG_START_DAY, d);
    cfg_valid <= 1'b0;
  endtask

  // Keep in_valid high after the item when no gap follows.
  task automatic send_offset(input logic [DAY_OFFSET_W-1:0] off, input bit paced);
    int gap;
    in_valid      <= 1'b1;
    in_day_offset <= off;
    do @(posedge clk); while (!in_ready);
    gap = paced ? pick_gap() : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Hold the sender until every predicted date has come back.
  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  initial begin : result_pacing
    int run;
    forever begin
      run = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 400) : $urandom_range(1, 30);
      out_ready <= 1'b1;
      repeat (run) @(posedge clk);
      run = pick_gap();
      if (run > 0) begin
        out_ready <= 1'b0;
        repeat (run) @(posedge clk);
      end
    end
  end

  initial begin : stimulus
    logic [CFG_DATA_W-1:0] y;
    logic [CFG_DATA_W-1:0] mo;
    logic [CFG_DATA_W-1:0] dy;
    int                    sent;
    int                    burst;
    bit                    steady;
    sent = 0;
    while (!rst_n) @(posedge clk);

    // start date out of reset: 2000-01-01
    send_offset(20'd0, 1'b1);
    send_offset(20'hFFFFF, 1'b1);
    send_offset(20'd59, 1'b1);
    send_offset(20'd365, 1'b1);
    send_offset(20'd366, 1'b1);
    send_offset(20'hAAAAA, 1'b1);
    send_offset(20'h55555, 1'b1);
    send_offset(DAY_OFFSET_W'(CYCLE_DAYS - 1), 1'b1);
    send_offset(DAY_OFFSET_W'(CYCLE_DAYS), 1'b1);

    // leap rules: plain century, 400-year century, year zero
    wait_drained();
    set_start(14'd1900, 14'd2, 14'd29);
    send_offset(20'd1, 1'b1);
    wait_drained();
    set_start(14'd2000, 14'd2, 14'd29);
    send_offset(20'd365, 1'b1);
    wait_drained();
    set_start(14'd0, 14'd2, 14'd29);
    send_offset(20'd366, 1'b1);

    // bad start dates: day past month end, month zero and above twelve, day zero
    wait_drained();
    set_start(14'd2023, 14'd4, 14'd31);
    send_offset(20'd10, 1'b1);
    wait_drained();
    set_start(14'd2023, 14'd0, 14'd10);
    send_offset(20'd10, 1'b1);
    wait_drained();
    set_start(14'd2023, 14'd13, 14'd1);
    send_offset(20'd10, 1'b1);
    wait_drained();
    set_start(14'h3FFF, 14'h3FFF, 14'h3FFF);
    send_offset(20'd10, 1'b1);
    wait_drained();
    set_start(14'd2023, 14'd12, 14'd0);
    send_offset(20'd10, 1'b1);

    // year rollover, then a year that wraps the result field
    wait_drained();
    set_start(14'd2023, 14'd12, 14'd31);
    send_offset(20'd1, 1'b1);
    wait_drained();
    set_start(14'h3FFF, 14'd12, 14'd31);
    send_offset(20'hFFFFF, 1'b1);

    // write to an index with no register; the date must stay put
    wait_drained();
    write_reg(CFG_NO_REG, 14'h3FFF);
    cfg_valid <= 1'b0;
    send_offset(20'd1, 1'b1);
    send_offset(20'd0, 1'b1);

    while (sent < ITEMS) begin
      wait_drained();
      case ($urandom_range(0, 9))
        0:          y = ($urandom_range(0, 1) == 0) ? 14'd0 : 14'h3FFF;
        1, 2, 3, 4: y = CFG_DATA_W'($urandom_range(1890, 2110));
        5, 6, 7, 8: y = CFG_DATA_W'($urandom_range(0, 9999));
        default:    y = CFG_DATA_W'($urandom);
      endcase
      mo = ($urandom_range(0, 9) == 0) ? CFG_DATA_W'($urandom_range(0, 15))
                                       : CFG_DATA_W'($urandom_range(1, 12));
      case ($urandom_range(0, 9))
        0:       dy = CFG_DATA_W'($urandom_range(29, 31));
        1:       dy = CFG_DATA_W'($urandom_range(0, 31));
        default: dy = CFG_DATA_W'($urandom_range(1, 28));
      endcase
      // junk above the register width must be ignored
      if ($urandom_range(0, 3) == 0) mo[CFG_DATA_W-1:MONTH_W] = (CFG_DATA_W-MONTH_W)'($urandom);
      if ($urandom_range(0, 3) == 0) dy[CFG_DATA_W-1:DAY_W] = (CFG_DATA_W-DAY_W)'($urandom);
      set_start(y, mo, dy);
      burst  = $urandom_range(4, 30);
      steady = ($urandom_range(0, 3) == 0);
      repeat (burst) begin
        send_offset(random_offset(), !steady);
        sent++;
      end
    end

    wait_drained();
    repeat (SETTLE) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

// File: filelist.f
rtl/dad_pkg.sv
rtl/dad_ctrl.sv
rtl/dad_dpath.sv
rtl/date_add_days.sv
tb/date_add_days_check.sv
tb/testbench.sv
